@@ sv/aes_pkg.sv @@
// Shared types, tables and round functions for the AES block cipher.
`timescale 1ns / 1ps

package aes_pkg;

    localparam logic [2:0] REG_KEY0    = 3'd0;
    localparam logic [2:0] REG_KEY1    = 3'd1;
    localparam logic [2:0] REG_KEY2    = 3'd2;
    localparam logic [2:0] REG_KEY3    = 3'd3;
    localparam logic [2:0] REG_KEY_LEN = 3'd4;

    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;
    localparam logic [1:0] KLEN_256 = 2'd2;

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } t_out_item;

    typedef struct packed {
        logic       exp_start;
        logic       exp_step;
        logic       capture;
        logic       init;
        logic       round;
        logic       dec;
        logic       first;
        logic       last;
        logic       out_load;
        logic [3:0] raddr;
    } t_dp_cmd;

    typedef struct packed {
        logic exp_last;
    } t_dp_sts;

    localparam logic [2047:0] SBOX_TBL = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [2047:0] ISBOX_TBL = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX_TBL[2047 - 8 * int'(b) -: 8];
    endfunction

    function automatic logic [7:0] isbox(input logic [7:0] b);
        return ISBOX_TBL[2047 - 8 * int'(b) -: 8];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] = sbox(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = isbox(s[127 - 8 * (4 * c + r) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] a);
        logic [7:0] a0, a1, a2, a3;
        a0 = a[31:24];
        a1 = a[23:16];
        a2 = a[15:8];
        a3 = a[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    function automatic logic [7:0] gm9(input logic [7:0] b);
        return xt(xt(xt(b))) ^ b;
    endfunction

    function automatic logic [7:0] gm11(input logic [7:0] b);
        return xt(xt(xt(b))) ^ xt(b) ^ b;
    endfunction

    function automatic logic [7:0] gm13(input logic [7:0] b);
        return xt(xt(xt(b))) ^ xt(xt(b)) ^ b;
    endfunction

    function automatic logic [7:0] gm14(input logic [7:0] b);
        return xt(xt(xt(b))) ^ xt(xt(b)) ^ xt(b);
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] a);
        logic [7:0] a0, a1, a2, a3;
        a0 = a[31:24];
        a1 = a[23:16];
        a2 = a[15:8];
        a3 = a[7:0];
        return {gm14(a0) ^ gm11(a1) ^ gm13(a2) ^ gm9(a3),
                gm9(a0) ^ gm14(a1) ^ gm11(a2) ^ gm13(a3),
                gm13(a0) ^ gm9(a1) ^ gm14(a2) ^ gm11(a3),
                gm11(a0) ^ gm13(a1) ^ gm9(a2) ^ gm14(a3)};
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s);
        return {mix_col(s[127:96]), mix_col(s[95:64]), mix_col(s[63:32]), mix_col(s[31:0])};
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        return {inv_mix_col(s[127:96]), inv_mix_col(s[95:64]),
                inv_mix_col(s[63:32]), inv_mix_col(s[31:0])};
    endfunction

endpackage

@@ sv/aes_dp.sv @@
// Datapath: key expansion, round-key memory and the round unit.
`timescale 1ns / 1ps

module aes_dp (
    input  logic               i_clk,
    input  aes_pkg::t_dp_cmd   i_cmd,
    output aes_pkg::t_dp_sts   o_sts,
    input  logic [255:0]       i_key,
    input  logic [1:0]         i_key_len,
    input  aes_pkg::t_in_item  i_item,
    output aes_pkg::t_out_item o_item
);
    import aes_pkg::*;

    logic [127:0] r_mem [16];
    logic [127:0] r_rk;
    logic [127:0] r_state;
    logic [127:0] r_res;
    logic [31:0]  r_win [8];
    logic [5:0]   r_idx;
    logic [2:0]   r_pos;
    logic [7:0]   r_rc;

    logic [2:0]   nk_m1;
    logic [5:0]   total_m1;
    logic [31:0]  temp;
    logic [31:0]  far_word;
    logic [31:0]  new_word;
    logic         is_key;
    logic [127:0] rnd_in;
    logic [127:0] rnd_out;

    always_comb begin
        case (i_key_len)
            KLEN_128: begin
                nk_m1    = 3'd3;
                total_m1 = 6'd43;
            end
            KLEN_192: begin
                nk_m1    = 3'd5;
                total_m1 = 6'd51;
            end
            default: begin
                nk_m1    = 3'd7;
                total_m1 = 6'd59;
            end
        endcase
    end

    assign is_key   = r_idx <= {3'd0, nk_m1};
    assign far_word = r_win[nk_m1];

    always_comb begin
        temp = r_win[0];
        if (r_pos == 3'd0) begin
            temp = sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rc, 24'd0};
        end else if (nk_m1 == 3'd7 && r_pos == 3'd4) begin
            temp = sub_word(r_win[0]);
        end
        new_word = is_key ? i_key[(7 - int'(r_idx[2:0])) * 32 +: 32] : (far_word ^ temp);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_start) begin
            r_idx <= '0;
            r_pos <= '0;
            r_rc  <= 8'h01;
        end else if (i_cmd.exp_step) begin
            r_idx <= r_idx + 6'd1;
            r_pos <= (r_pos == nk_m1) ? 3'd0 : r_pos + 3'd1;
            if (r_pos == 3'd0 && !is_key) begin
                r_rc <= xt(r_rc);
            end
            r_win[0] <= new_word;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k - 1];
            end
            if (r_idx[1:0] == 2'd3) begin
                r_mem[r_idx[5:2]] <= {r_win[2], r_win[1], r_win[0], new_word};
            end
        end
        r_rk <= r_mem[i_cmd.raddr];
    end

    assign o_sts.exp_last = r_idx == total_m1;

    always_comb begin
        if (i_cmd.dec) begin
            rnd_in  = i_cmd.first ? r_state : inv_mix(r_state);
            rnd_out = inv_sub_shift(rnd_in);
        end else begin
            rnd_in  = sub_shift(r_state);
            rnd_out = i_cmd.last ? rnd_in : mix(rnd_in);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_state <= {i_item.block_hi, i_item.block_lo};
        end else if (i_cmd.init) begin
            r_state <= r_state ^ r_rk;
        end else if (i_cmd.round) begin
            r_state <= rnd_out ^ r_rk;
        end
        if (i_cmd.out_load) begin
            r_res <= r_state;
        end
    end

    assign o_item.result_hi = r_res[127:64];
    assign o_item.result_lo = r_res[63:0];

endmodule

@@ sv/aes_ctrl.sv @@
// Controller: sequences key expansion, rounds and the output register.
`timescale 1ns / 1ps

module aes_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_cmd,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  logic             i_cfg_wr,
    input  logic [1:0]       i_key_len,
    output aes_pkg::t_dp_cmd o_cmd,
    input  aes_pkg::t_dp_sts i_sts
);
    import aes_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXPAND = 6'b000010,
        S_PREP   = 6'b000100,
        S_INIT   = 6'b001000,
        S_ROUND  = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state     r_state, n_state;
    logic       r_keys_ready, n_keys_ready;
    logic       r_dec, n_dec;
    logic [3:0] r_round, n_round;
    logic       r_out_valid, n_out_valid;
    logic [3:0] nr;
    logic       accept;
    logic       slot_free;

    always_comb begin
        case (i_key_len)
            KLEN_128: nr = 4'd10;
            KLEN_192: nr = 4'd12;
            default:  nr = 4'd14;
        endcase
    end

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_keys_ready = r_keys_ready;
        n_dec        = r_dec;
        n_round      = r_round;
        o_cmd        = '0;
        o_cmd.dec    = r_dec;
        o_cmd.first  = r_round == 4'd1;
        o_cmd.last   = r_round == nr;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture   = 1'b1;
                    o_cmd.exp_start = !r_keys_ready;
                    n_dec           = i_in_cmd;
                    n_state         = r_keys_ready ? S_PREP : S_EXPAND;
                end
            end
            S_EXPAND: begin
                o_cmd.exp_step = 1'b1;
                if (i_sts.exp_last) begin
                    n_keys_ready = 1'b1;
                    n_state      = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.raddr = (r_dec == CMD_DEC) ? nr : 4'd0;
                n_state     = S_INIT;
            end
            S_INIT: begin
                o_cmd.init  = 1'b1;
                o_cmd.raddr = (r_dec == CMD_DEC) ? nr - 4'd1 : 4'd1;
                n_round     = 4'd1;
                n_state     = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                o_cmd.raddr = (r_dec == CMD_DEC) ? nr - r_round - 4'd1 : r_round + 4'd1;
                n_round     = r_round + 4'd1;
                if (r_round == nr) begin
                    n_round = 4'd0;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_wr) begin
            n_keys_ready = 1'b0;
        end
        n_out_valid = o_cmd.out_load ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_keys_ready <= 1'b0;
            r_dec        <= CMD_ENC;
            r_round      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_keys_ready <= n_keys_ready;
            r_dec        <= n_dec;
            r_round      <= n_round;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

    a_round_keys_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND || r_state == S_INIT) |-> r_keys_ready)
        else $error("Round started without an expanded key.");

    a_expand_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXPAND) |-> !r_keys_ready)
        else $error("Expansion running with keys already ready.");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_round != 4'd0 && r_round <= nr))
        else $error("Round counter out of range.");

    a_finish_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !r_out_valid) |=> (r_state == S_IDLE && r_out_valid))
        else $error("Result not delivered to a free output register.");

endmodule

@@ sv/aes_block_encrypt_decrypt.sv @@
// Top level of the AES block cipher with its configuration registers.
`timescale 1ns / 1ps

// AES-128/192/256 cipher for one 128-bit block per item, encrypt or decrypt.
// The key words and the key length are written over the APB port, which the
// user must do only while the block is idle; the block does not enforce it.
// Each write to them marks the round keys stale. The input channel carries a
// command and the block; the output channel carries the result. An item is
// taken only while the core is idle. With stale round keys, the item first
// runs the key schedule, one word per cycle, 44, 52 or 60 words for 128, 192
// or 256-bit keys. It then runs the first key addition and Nr rounds (Nr is
// 10, 12 or 14; one round per cycle through a single round unit reading one
// key row a cycle); no new item is taken until the result is in the output
// register, which holds it for a stalled receiver, and a finished item
// waits for the register to free up. Reset clears the APB and control
// registers and marks the keys stale; the round-key memory is not cleared.
module aes_block_encrypt_decrypt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    input  aes_pkg::t_in_item  i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output aes_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import aes_pkg::*;

    logic [63:0] r_key0, r_key1, r_key2, r_key3;
    logic [1:0]  r_key_len;
    logic        wr;
    logic        cfg_wr;
    t_dp_cmd     cmd;
    t_dp_sts     sts;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign cfg_wr = wr && (paddr[5:3] <= REG_KEY_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0    <= '0;
            r_key1    <= '0;
            r_key2    <= '0;
            r_key3    <= '0;
            r_key_len <= '0;
        end else if (wr) begin
            case (paddr[5:3])
                REG_KEY0:    r_key0    <= pwdata;
                REG_KEY1:    r_key1    <= pwdata;
                REG_KEY2:    r_key2    <= pwdata;
                REG_KEY3:    r_key3    <= pwdata;
                REG_KEY_LEN: r_key_len <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_KEY0:    prdata = r_key0;
            REG_KEY1:    prdata = r_key1;
            REG_KEY2:    prdata = r_key2;
            REG_KEY3:    prdata = r_key3;
            REG_KEY_LEN: prdata = {62'd0, r_key_len};
            default:     prdata = '0;
        endcase
    end

    aes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in_item.cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_wr    (cfg_wr),
        .i_key_len   (r_key_len),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    aes_dp u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_key     ({r_key0, r_key1, r_key2, r_key3}),
        .i_key_len (r_key_len),
        .i_item    (i_in_item),
        .o_item    (o_out_item)
    );

endmodule

@@ sim/aes_block_encrypt_decrypt_tb.sv @@
// Self-checking testbench for the AES block cipher top level.
`timescale 1ns / 1ps

module aes_block_encrypt_decrypt_tb;
    import aes_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        i_in_valid;
    t_in_item    i_in_item;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        i_out_stall;

    logic [63:0] key_reg [4];
    logic [1:0]  key_len_reg;
    logic [31:0] round_keys [60];
    t_out_item   expected_blocks [1024];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct;
    int          stall_pct;

    aes_block_encrypt_decrypt DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .i_in_item(i_in_item), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out_item(o_out_item), .i_out_stall(i_out_stall)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic logic [7:0] gf_mul(input logic [7:0] b, input int m);
        logic [7:0] r;
        r = 8'h00;
        for (int k = 0; k < 4; k++) begin
            if (m[k]) r ^= b;
            b = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [31:0] sub_word32(input logic [31:0] w);
        logic [31:0] r;
        for (int j = 0; j < 4; j++) r[8 * j +: 8] = SBOX_TBL[2047 - 8 * int'(w[8 * j +: 8]) -: 8];
        return r;
    endfunction

    function automatic int round_count();
        return (key_len_reg == KLEN_128) ? 10 : (key_len_reg == KLEN_192) ? 12 : 14;
    endfunction

    task automatic build_round_keys();
        int nk;
        int rc;
        logic [31:0] t;
        nk = (key_len_reg == KLEN_128) ? 4 : (key_len_reg == KLEN_192) ? 6 : 8;
        for (int i = 0; i < nk; i++)
            round_keys[i] = i[0] ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
        rc = 1;
        for (int i = nk; i < 4 * (nk + 7); i++) begin
            t = round_keys[i - 1];
            if (i % nk == 0) begin
                t = sub_word32({t[23:0], t[31:24]}) ^ {rc[7:0], 24'h0};
                rc = (rc & 8'h80) ? ((rc << 1) ^ 9'h11b) : (rc << 1);
            end else if (nk == 8 && i % 8 == 4) begin
                t = sub_word32(t);
            end
            round_keys[i] = round_keys[i - nk] ^ t;
        end
    endtask

    function automatic logic [127:0] with_round_key(input logic [127:0] s, input int rnd);
        return s ^ {round_keys[4 * rnd], round_keys[4 * rnd + 1],
                    round_keys[4 * rnd + 2], round_keys[4 * rnd + 3]};
    endfunction

    function automatic logic [127:0] shifted_sub(input logic [127:0] s, input bit inv);
        logic [127:0] t;
        int src;
        int dst;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (!inv) begin
                    dst = 4 * c + r;
                    src = 4 * ((c + r) % 4) + r;
                    t[127 - 8 * dst -: 8] = SBOX_TBL[2047 - 8 * int'(s[127 - 8 * src -: 8]) -: 8];
                end else begin
                    src = 4 * c + r;
                    dst = 4 * ((c + r) % 4) + r;
                    t[127 - 8 * dst -: 8] = ISBOX_TBL[2047 - 8 * int'(s[127 - 8 * src -: 8]) -: 8];
                end
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mixed_columns(input logic [127:0] s, input bit inv);
        int coef [4];
        logic [7:0] col [4];
        logic [7:0] v;
        logic [127:0] t;
        if (inv) coef = '{14, 11, 13, 9};
        else coef = '{2, 3, 1, 1};
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) col[k] = s[127 - 8 * (4 * c + k) -: 8];
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++) v ^= gf_mul(col[k], coef[(k - r + 4) % 4]);
                t[127 - 8 * (4 * c + r) -: 8] = v;
            end
        end
        return t;
    endfunction

    function automatic t_out_item cipher_block(input t_in_item it);
        logic [127:0] s;
        int nr;
        nr = round_count();
        s = {it.block_hi, it.block_lo};
        if (it.cmd == CMD_ENC) begin
            s = with_round_key(s, 0);
            for (int r = 1; r <= nr; r++) begin
                s = shifted_sub(s, 1'b0);
                if (r != nr) s = mixed_columns(s, 1'b0);
                s = with_round_key(s, r);
            end
        end else begin
            s = with_round_key(s, nr);
            for (int r = 1; r <= nr; r++) begin
                if (r != 1) s = mixed_columns(s, 1'b1);
                s = shifted_sub(s, 1'b1);
                s = with_round_key(s, nr - r);
            end
        end
        return s;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_KEY_LEN) key_len_reg = value[1:0];
        else if (idx < REG_KEY_LEN) key_reg[idx[1:0]] = value;
        build_round_keys();
    endtask

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic load_key(input logic [1:0] len, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        drain_and_settle();
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_KEY_LEN, {62'd0, len});
    endtask

    task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
        t_in_item it;
        it.cmd = op;
        it.block_hi = hi;
        it.block_lo = lo;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_blocks[exp_wr[9:0]] = cipher_block(it);
        exp_wr++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_known_vectors();
        load_key(KLEN_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0);
        send_block(CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(CMD_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        load_key(KLEN_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h0);
        send_block(CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(CMD_DEC, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        load_key(KLEN_256, 64'h0, 64'h0, 64'h0, 64'h0);
    endtask

    task automatic test_field_extremes();
        load_key(KLEN_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(CMD_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        send_block(CMD_ENC, 64'h0, 64'h0);
        send_block(CMD_DEC, '1, '1);
        load_key(KLEN_128, '1, '1, '1, '1);
        send_block(CMD_ENC, '1, 64'h0);
        send_block(CMD_DEC, 64'h0, '1);
        // Length code three behaves as a 256-bit key.
        load_key(2'd3, '1, 64'h0, '1, 64'h0);
        send_block(CMD_ENC, 64'h8000000000000000, 64'h1);
        send_block(CMD_DEC, 64'h1, 64'h8000000000000000);
        // A write to an address past the registers changes nothing.
        drain_and_settle();
        write_reg(3'd7, rand64());
        send_block(CMD_ENC, rand64(), rand64());
    endtask

    task automatic test_key_change_between_items();
        for (int k = 0; k < 3; k++) begin
            load_key(2'(k), rand64(), rand64(), rand64(), rand64());
            send_block(CMD_ENC, rand64(), rand64());
            drain_and_settle();
            write_reg(3'($urandom_range(3)), rand64());
            send_block(CMD_DEC, rand64(), rand64());
        end
    endtask

    task automatic test_random_blocks(input int count, input int sender_idle, input int stall);
        send_idle_pct = sender_idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0)
                load_key(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64());
            send_block(1'($urandom_range(1)), rand64(), rand64());
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_wr == exp_rd) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result item %h", o_out_item);
            end else begin
                want = expected_blocks[exp_rd[9:0]];
                exp_rd++;
                if (o_out_item.result_hi !== want.result_hi ||
                    o_out_item.result_lo !== want.result_lo) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Result mismatch: expected %h_%h, got %h_%h",
                                 want.result_hi, want.result_lo,
                                 o_out_item.result_hi, o_out_item.result_lo);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        send_idle_pct = 0;
        stall_pct = 0;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        key_len_reg = KLEN_128;
        build_round_keys();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_known_vectors();
        test_field_extremes();
        test_key_change_between_items();
        test_random_blocks(190, 0, 0);
        test_random_blocks(180, 51, 0);
        test_random_blocks(180, 0, 51);
        test_random_blocks(180, 23, 23);
        drain_and_settle();
        if (mismatch_count == 0 && exp_wr == exp_rd) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

@@ sim.f @@
sv/aes_pkg.sv
sv/aes_dp.sv
sv/aes_ctrl.sv
sv/aes_block_encrypt_decrypt.sv
sim/aes_block_encrypt_decrypt_tb.sv
